### rtl/brc_pkg.sv
package brc_pkg;

  // Register indexes on the calibration write port.
  typedef enum logic [2:0] {
    REG_SENS_BASE       = 3'd0,
    REG_OFF_BASE        = 3'd1,
    REG_SENS_TEMP_COEFF = 3'd2,
    REG_OFF_TEMP_COEFF  = 3'd3,
    REG_REF_TEMP        = 3'd4,
    REG_TEMP_GAIN       = 3'd5
  } brc_reg_t;

  typedef struct packed {
    logic [15:0] sens_base;
    logic [15:0] off_base;
    logic [15:0] sens_temp_coeff;
    logic [15:0] off_temp_coeff;
    logic [15:0] ref_temp;
    logic [15:0] temp_gain;
  } brc_cal_t;

  localparam brc_cal_t CAL_RESET = '{
    sens_base:       16'd40127,
    off_base:        16'd36924,
    sens_temp_coeff: 16'd23317,
    off_temp_coeff:  16'd23282,
    ref_temp:        16'd33464,
    temp_gain:       16'd28312
  };

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } sample_t;

  typedef struct packed {
    logic signed [18:0] temp_centideg;
    logic signed [31:0] press_centimbar;
  } result_t;

  // Temperature thresholds in 0.01 degC.
  localparam logic signed [19:0] TEMP_MID  = 20'sd2000;
  localparam logic signed [19:0] TEMP_COLD = -20'sd1500;

  localparam int unsigned NUM_STAGES = 11;

  // Signed division by 2^sh, truncating toward zero.
  function automatic logic signed [63:0] trunc_shift(input logic signed [63:0] x,
                                                     input int unsigned sh);
    logic signed [63:0] bias;
    bias = x[63] ? $signed((64'd1 << sh) - 64'd1) : 64'sd0;
    return (x + bias) >>> sh;
  endfunction

endpackage

### rtl/barometer_raw_compensation.sv
// Each accepted sample passes through the eleven pipeline stages to its result.
// Throughput: one sample per cycle while the result is not stalled; every stage
// holds one transaction and moves on as soon as the stage after it is free.
// Reset (synchronous, rst high) empties the pipeline and restores the factory
// calibration words.
module barometer_raw_compensation
  import brc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  brc_cal_t cal;

  brc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  brc_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cal          (cal),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

### rtl/brc_cfg.sv
module brc_cfg
  import brc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output brc_cal_t    cal
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= CAL_RESET;
    end else if (cfg_we) begin
      case (brc_reg_t'(cfg_index))
        REG_SENS_BASE:       cal.sens_base       <= cfg_data;
        REG_OFF_BASE:        cal.off_base        <= cfg_data;
        REG_SENS_TEMP_COEFF: cal.sens_temp_coeff <= cfg_data;
        REG_OFF_TEMP_COEFF:  cal.off_temp_coeff  <= cfg_data;
        REG_REF_TEMP:        cal.ref_temp        <= cfg_data;
        REG_TEMP_GAIN:       cal.temp_gain       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/brc_pipe.sv
module brc_pipe
  import brc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  brc_cal_t cal,
  input  logic     sample_valid,
  output logic     sample_stall,
  input  sample_t  sample,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] en;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !v[NUM_STAGES-1] || !result_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? sample_valid : v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign sample_stall = !en[0];
  assign result_valid = v[NUM_STAGES-1];

  // Stage 1: temperature difference from the reference.
  logic signed [24:0] s1_dt;
  logic [23:0]        s1_d1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_dt <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'h00});
      s1_d1 <= sample.raw_pressure;
    end
  end

  // Stage 2: the four products of dT.
  logic signed [41:0] s2_ptg, s2_pot, s2_pst;
  logic [47:0]        s2_dsq;
  logic [23:0]        s2_d1;
  logic signed [49:0] dsq_full;

  assign dsq_full = s1_dt * s1_dt;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ptg <= s1_dt * $signed({1'b0, cal.temp_gain});
      s2_pot <= s1_dt * $signed({1'b0, cal.off_temp_coeff});
      s2_pst <= s1_dt * $signed({1'b0, cal.sens_temp_coeff});
      s2_dsq <= dsq_full[47:0];
      s2_d1  <= s1_d1;
    end
  end

  // Stage 3: first-order temperature, offset and sensitivity.
  logic signed [63:0] ptg_q, pot_q, pst_q;
  logic signed [19:0] s3_temp;
  logic signed [35:0] s3_off, s3_sens;
  logic [16:0]        s3_t2;
  logic [23:0]        s3_d1;

  assign ptg_q = trunc_shift({{22{s2_ptg[41]}}, s2_ptg}, 23);
  assign pot_q = trunc_shift({{22{s2_pot[41]}}, s2_pot}, 7);
  assign pst_q = trunc_shift({{22{s2_pst[41]}}, s2_pst}, 8);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_temp <= $signed(ptg_q[19:0]) + TEMP_MID;
      s3_off  <= $signed({4'b0, cal.off_base, 16'h0000}) + $signed(pot_q[35:0]);
      s3_sens <= $signed({5'b0, cal.sens_base, 15'h0000}) + $signed(pst_q[35:0]);
      s3_t2   <= s2_dsq[47:31];
      s3_d1   <= s2_d1;
    end
  end

  // Stage 4: second-order thresholds. The deviations are forced to zero when a
  // correction does not apply, so the later terms vanish on their own.
  logic               low, cold;
  logic signed [19:0] dev_full, cd_full;
  logic [17:0]        s4_dev, s4_cd;
  logic signed [19:0] s4_temp;
  logic signed [35:0] s4_off, s4_sens;
  logic [23:0]        s4_d1;

  assign low      = s3_temp < TEMP_MID;
  assign cold     = s3_temp < TEMP_COLD;
  assign dev_full = TEMP_MID - s3_temp;
  assign cd_full  = TEMP_COLD - s3_temp;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_dev  <= low ? dev_full[17:0] : 18'd0;
      s4_cd   <= cold ? cd_full[17:0] : 18'd0;
      s4_temp <= low ? s3_temp - $signed({3'b000, s3_t2}) : s3_temp;
      s4_off  <= s3_off;
      s4_sens <= s3_sens;
      s4_d1   <= s3_d1;
    end
  end

  // Stage 5: squares of the deviations.
  logic [35:0]        s5_sq, s5_csq;
  logic signed [19:0] s5_temp;
  logic signed [35:0] s5_off, s5_sens;
  logic [23:0]        s5_d1;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_sq   <= s4_dev * s4_dev;
      s5_csq  <= s4_cd * s4_cd;
      s5_temp <= s4_temp;
      s5_off  <= s4_off;
      s5_sens <= s4_sens;
      s5_d1   <= s4_d1;
    end
  end

  // Stage 6: correction terms by shift and add.
  logic [39:0]        five_sq, seven_csq, eleven_csq, off2_sum, sens2_sum;
  logic [37:0]        s6_off2, s6_sens2;
  logic signed [19:0] s6_temp;
  logic signed [35:0] s6_off, s6_sens;
  logic [23:0]        s6_d1;

  assign five_sq    = {2'b00, s5_sq, 2'b00} + {4'h0, s5_sq};
  assign seven_csq  = {1'b0, s5_csq, 3'b000} - {4'h0, s5_csq};
  assign eleven_csq = {1'b0, s5_csq, 3'b000} + {3'b000, s5_csq, 1'b0} + {4'h0, s5_csq};
  assign off2_sum   = {1'b0, five_sq[39:1]} + seven_csq;
  assign sens2_sum  = {2'b00, five_sq[39:2]} + {1'b0, eleven_csq[39:1]};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_off2  <= off2_sum[37:0];
      s6_sens2 <= sens2_sum[37:0];
      s6_temp  <= s5_temp;
      s6_off   <= s5_off;
      s6_sens  <= s5_sens;
      s6_d1    <= s5_d1;
    end
  end

  // Stage 7: corrected offset and sensitivity.
  logic signed [39:0] s7_off, s7_sens;
  logic signed [19:0] s7_temp;
  logic [23:0]        s7_d1;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_off  <= $signed({{4{s6_off[35]}}, s6_off}) - $signed({2'b00, s6_off2});
      s7_sens <= $signed({{4{s6_sens[35]}}, s6_sens}) - $signed({2'b00, s6_sens2});
      s7_temp <= s6_temp;
      s7_d1   <= s6_d1;
    end
  end

  // Stage 8: raw pressure times sensitivity, in two partial products.
  logic [43:0]        s8_pp_lo;
  logic signed [44:0] s8_pp_hi;
  logic signed [39:0] s8_off;
  logic signed [19:0] s8_temp;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_pp_lo <= s7_d1 * s7_sens[19:0];
      s8_pp_hi <= $signed({1'b0, s7_d1}) * $signed(s7_sens[39:20]);
      s8_off   <= s7_off;
      s8_temp  <= s7_temp;
    end
  end

  // Stage 9: combine the partial products. The full product fits 64 bits.
  logic signed [63:0] s9_prod;
  logic signed [39:0] s9_off;
  logic signed [19:0] s9_temp;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_prod <= $signed({s8_pp_hi[43:0], 20'h00000}) + $signed({20'h00000, s8_pp_lo});
      s9_off  <= s8_off;
      s9_temp <= s8_temp;
    end
  end

  // Stage 10: scale the product and remove the offset.
  logic signed [63:0] prod_q;
  logic signed [43:0] s10_diff;
  logic signed [19:0] s10_temp;

  assign prod_q = trunc_shift(s9_prod, 21);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_diff <= $signed(prod_q[43:0]) - $signed({{4{s9_off[39]}}, s9_off});
      s10_temp <= s9_temp;
    end
  end

  // Stage 11: final scaling into the output register.
  logic signed [63:0] press_q;

  assign press_q = trunc_shift({{20{s10_diff[43]}}, s10_diff}, 15);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      result.temp_centideg   <= s10_temp[18:0];
      result.press_centimbar <= press_q[31:0];
    end
  end

endmodule

### rtl/brc_check.sv
module brc_check
  import brc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result payload changed while stalled");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered straight after reset");

  // Samples are only held back when the pipeline is full behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("sample stalled while the output is moving");

endmodule

bind barometer_raw_compensation brc_check u_brc_check (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
